// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker in sfpb_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SFPB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SFPB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sfpb_pkg.sv -----
// ---------------------------------------------------------------------------
// sfpb_pkg
// Types and constants for the soft-bit frame to packed byte unit.
// ---------------------------------------------------------------------------
package sfpb_pkg;

  localparam int unsigned MAX_FRAME_BITS_DEF = 1280;
  localparam logic [10:0] MAX_BITS_RST       = 11'd1280;

  localparam logic [15:0] SYNC_ERASED  = 16'h6B20;
  localparam logic [15:0] SYNC_LAST    = 16'h6B2F;
  localparam logic [15:0] SOFT_ZERO_LO = 16'h0001;
  localparam logic [15:0] SOFT_ZERO_HI = 16'h007F;
  localparam logic [15:0] SOFT_ONE_LO  = 16'h0081;
  localparam logic [15:0] SOFT_ONE_HI  = 16'h00FF;

  typedef struct packed {
    logic [15:0] word;
    logic        frame_start;
  } sfpb_in_t;

  typedef struct packed {
    logic [7:0]  packed_byte;
    logic        byte_present;
    logic        frame_done;
    logic        erasure;
    logic [10:0] bit_count;
  } sfpb_out_t;

endpackage

// ----- sv/softbit_frame_to_packed_bytes_unit.sv -----
// ---------------------------------------------------------------------------
// softbit_frame_to_packed_bytes_unit
// Packs a G.192 soft-bit frame into bytes, MSB first, with frame status.
// ---------------------------------------------------------------------------
// Usage:
// - in_*: one 16-bit G.192 word per transaction; frame_start marks the sync
//   word. A sync, then a length, then one soft-bit word per bit.
// - out_*: at most one result per input word: a full byte, the last
//   (left-aligned) byte with frame_done, or a frame_done status alone on a
//   header error or zero length. Sync and most bit words give no result.
// - cfg_*: writes the max_frame_bits limit; always ready, write when idle.
// - The result is registered: it is on out_valid in the cycle after its word is taken.
// - Throughput: one word per cycle when not stalled; classify, shift and
//   count all sit in a single stage between handshake and result register.
// - A stalled receiver holds the result register; a new word is still taken
//   in the cycle that register drains, so in_ready = !out_valid | out_ready.
// - Reset waits for a sync word, sets the limit to 1280 and drops any
//   pending result.
// ---------------------------------------------------------------------------
module softbit_frame_to_packed_bytes_unit #(
  parameter int unsigned MAX_FRAME_BITS = sfpb_pkg::MAX_FRAME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfpb_pkg::sfpb_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sfpb_pkg::sfpb_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [10:0]         cfg_max_frame_bits
);
  import sfpb_pkg::*;

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BITS = 2'd2;
  localparam logic [15:0] LimitMax = 16'(MAX_FRAME_BITS);

  logic [10:0] max_bits_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [10:0] bits_left_r, bits_left_nxt;
  logic [10:0] frame_bits_r, frame_bits_nxt;
  logic [7:0]  byte_accum_r, byte_accum_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic        bad_seen_r, bad_seen_nxt;
  logic        erased_sync_r, erased_sync_nxt;
  logic        out_valid_r, out_valid_nxt;
  sfpb_out_t   out_data_r, out_data_nxt;

  logic        accept;
  logic [15:0] w;
  logic [15:0] cfg_lim;
  logic [15:0] limit;
  logic        is_one;
  logic        is_zero;
  logic [7:0]  accum_set;
  logic [10:0] left_dec;
  logic        bad_now;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign w         = in_data.word;
  assign cfg_lim   = {5'd0, max_bits_r};
  assign limit     = (cfg_lim > LimitMax) ? LimitMax : cfg_lim;
  assign is_one    = w inside {[SOFT_ONE_LO:SOFT_ONE_HI]};
  assign is_zero   = w inside {[SOFT_ZERO_LO:SOFT_ZERO_HI]};
  assign accum_set = byte_accum_r | (is_one ? (8'd1 << bit_index_r) : 8'd0);
  assign left_dec  = bits_left_r - 11'd1;
  assign bad_now   = bad_seen_r || (!is_one && !is_zero);

  always_comb begin
    phase_nxt       = phase_r;
    bits_left_nxt   = bits_left_r;
    frame_bits_nxt  = frame_bits_r;
    byte_accum_nxt  = byte_accum_r;
    bit_index_nxt   = bit_index_r;
    bad_seen_nxt    = bad_seen_r;
    erased_sync_nxt = erased_sync_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b0;
      out_data_nxt  = '0;
      if (in_data.frame_start) begin
        if ((w < SYNC_ERASED) || (w > SYNC_LAST)) begin
          phase_nxt               = PH_SYNC;
          out_valid_nxt           = 1'b1;
          out_data_nxt.frame_done = 1'b1;
          out_data_nxt.erasure    = 1'b1;
        end else begin
          erased_sync_nxt = (w == SYNC_ERASED);
          phase_nxt       = PH_LEN;
        end
      end else begin
        case (phase_r)
          PH_LEN: begin
            phase_nxt = PH_SYNC;
            if (w[15] || (w > limit)) begin
              out_valid_nxt           = 1'b1;
              out_data_nxt.frame_done = 1'b1;
              out_data_nxt.erasure    = 1'b1;
            end else if (w == 16'd0) begin
              out_valid_nxt           = 1'b1;
              out_data_nxt.frame_done = 1'b1;
              out_data_nxt.erasure    = erased_sync_r;
            end else begin
              bits_left_nxt  = 11'(w);
              frame_bits_nxt = 11'(w);
              byte_accum_nxt = 8'd0;
              bit_index_nxt  = 3'd7;
              bad_seen_nxt   = 1'b0;
              phase_nxt      = PH_BITS;
            end
          end
          PH_BITS: begin
            bad_seen_nxt  = bad_now;
            bits_left_nxt = left_dec;
            if (left_dec == 11'd0) begin
              byte_accum_nxt            = 8'd0;
              bit_index_nxt             = 3'd7;
              phase_nxt                 = PH_SYNC;
              out_valid_nxt             = 1'b1;
              out_data_nxt.packed_byte  = accum_set;
              out_data_nxt.byte_present = 1'b1;
              out_data_nxt.frame_done   = 1'b1;
              out_data_nxt.erasure      = bad_now || erased_sync_r;
              out_data_nxt.bit_count    = frame_bits_r;
            end else if (bit_index_r == 3'd0) begin
              byte_accum_nxt            = 8'd0;
              bit_index_nxt             = 3'd7;
              out_valid_nxt             = 1'b1;
              out_data_nxt.packed_byte  = accum_set;
              out_data_nxt.byte_present = 1'b1;
            end else begin
              byte_accum_nxt = accum_set;
              bit_index_nxt  = bit_index_r - 3'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bits_r    <= MAX_BITS_RST;
      phase_r       <= PH_SYNC;
      bits_left_r   <= 11'd0;
      frame_bits_r  <= 11'd0;
      byte_accum_r  <= 8'd0;
      bit_index_r   <= 3'd7;
      bad_seen_r    <= 1'b0;
      erased_sync_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_bits_r <= cfg_max_frame_bits;
      end
      phase_r       <= phase_nxt;
      bits_left_r   <= bits_left_nxt;
      frame_bits_r  <= frame_bits_nxt;
      byte_accum_r  <= byte_accum_nxt;
      bit_index_r   <= bit_index_nxt;
      bad_seen_r    <= bad_seen_nxt;
      erased_sync_r <= erased_sync_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- sv/sfpb_checker.sv -----
// ---------------------------------------------------------------------------
// sfpb_checker
// Port-level checks for the soft-bit frame to packed byte unit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfpb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sfpb_pkg::sfpb_out_t out_data
);

  `SFPB_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "result pending after reset")

  `SFPB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data),
    "stalled result changed")

  `SFPB_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

  `SFPB_ASSERT(a_status_only_at_done,
    out_valid && !out_data.frame_done |-> !out_data.erasure && out_data.bit_count == 11'd0,
    "frame status outside frame end")

  `SFPB_ASSERT(a_byte_zero_when_absent,
    out_valid && !out_data.byte_present |-> out_data.packed_byte == 8'd0 &&
    out_data.frame_done, "status-only result carries data")

endmodule

bind softbit_frame_to_packed_bytes_unit sfpb_checker u_sfpb_checker (.*);
